>>> rtl/assert_macros.svh
// assertion macros shared by the packer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/mbp_pkg.sv
// types and constants of the msb-first bit packer
`default_nettype none
package mbp_pkg;
    localparam int WORD_BITS = 32;
    localparam int COUNT_W   = 6;
    localparam int POS_W     = 5;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_ALIGN = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_ALIGN = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [WORD_BITS-1:0] TOP_BIT  = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]           kind;
        logic [WORD_BITS-1:0] value;
        logic [COUNT_W-1:0]   nbits;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;
endpackage
`default_nettype wire

>>> rtl/mbp_in_if.sv
// input channel of the packer
`default_nettype none
interface mbp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] field_value;
    logic [5:0]  field_bits;

    modport source (output valid, output action, output field_value, output field_bits,
                    input ready);
    modport sink (input valid, input action, input field_value, input field_bits,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/mbp_out_if.sv
// output channel of the packer
`default_nettype none
interface mbp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_word;
    logic [5:0]  used_bits;

    modport source (output valid, output packed_word, output used_bits, input ready);
    modport sink (input valid, input packed_word, input used_bits, output ready);
endinterface
`default_nettype wire

>>> rtl/msb_first_bit_packer.sv
// top level of the msb-first bit packer
`default_nettype none
// Packs write, align and flush items into 32-bit words, first bit at bit 31.
// One item is accepted per clock while the two-entry queue between the front
// end and the packing stage has room; the packing stage retires one queued item
// per clock whenever its output register is empty or being taken, so the
// sustained rate is one item per cycle; an item is registered in the queue,
// and the word it completes in the output register, before being offered. A
// word is offered with used_bits 32 when it fills, or with the pending count
// on flush; writes of zero bits and unknown actions are accepted and dropped.
module msb_first_bit_packer (
    input  wire       clk,
    input  wire       rst_n,
    mbp_in_if.sink    in_ch,
    mbp_out_if.source out_ch
);
    mbp_pkg::push_t     push;
    mbp_pkg::op_t       head;
    mbp_pkg::q_status_t q_status;
    logic               pop;

    mbp_front u_front (
        .in_ch    (in_ch),
        .q_status (q_status),
        .push     (push)
    );

    mbp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    mbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );
endmodule
`default_nettype wire

>>> rtl/mbp_front.sv
// front end: accepts items, drops no-ops, clamps and masks write fields
`default_nettype none
module mbp_front (
    mbp_in_if.sink                  in_ch,
    input  wire mbp_pkg::q_status_t q_status,
    output mbp_pkg::push_t          push
);
    logic [mbp_pkg::COUNT_W-1:0]   nbits;
    logic [mbp_pkg::WORD_BITS-1:0] mask;
    logic                          keep;

    assign in_ch.ready = !q_status.full;

    always_comb
    begin
        // counts above a word are taken as a full word
        nbits = in_ch.field_bits[5] ? 6'd32 : in_ch.field_bits;
        mask  = mbp_pkg::ALL_ONES >> (6'd32 - nbits);
        case (in_ch.action)
            mbp_pkg::ACT_WRITE: keep = (in_ch.field_bits != 6'd0);
            mbp_pkg::ACT_ALIGN: keep = 1'b1;
            mbp_pkg::ACT_FLUSH: keep = 1'b1;
            default:            keep = 1'b0;
        endcase
        push.valid    = in_ch.valid && !q_status.full && keep;
        push.op.kind  = in_ch.action;
        push.op.value = in_ch.field_value & mask;
        push.op.nbits = nbits;
    end
endmodule
`default_nettype wire

>>> rtl/mbp_queue.sv
// two-entry queue between front and back
`default_nettype none
`include "assert_macros.svh"
module mbp_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire mbp_pkg::push_t push,
    input  wire                 pop,
    output mbp_pkg::op_t        head,
    output mbp_pkg::q_status_t  status
);
    mbp_pkg::op_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.op;
        end
    end

    `ASSERT_ALWAYS(a_no_push_when_full, clk, rst_n, !(status.full && push.valid))
    `ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg != 2'd3)
    `ASSERT_ALWAYS(a_ptrs_match_count, clk, rst_n,
                   (wr_ptr_reg == rd_ptr_reg) == (count_reg[0] == 1'b0))
endmodule
`default_nettype wire

>>> rtl/mbp_back.sv
// back end: packs queued ops into words and holds the output register
`default_nettype none
`include "assert_macros.svh"
module mbp_back (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire mbp_pkg::op_t       head,
    input  wire mbp_pkg::q_status_t q_status,
    output logic                    pop,
    mbp_out_if.source               out_ch
);
    logic [mbp_pkg::WORD_BITS-1:0] pend_reg, pend_next;
    logic [mbp_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mbp_pkg::WORD_BITS-1:0] word_reg, word_next;
    logic [mbp_pkg::COUNT_W-1:0]   used_reg, used_next;

    logic [3:0]                    pad_len;
    logic [mbp_pkg::WORD_BITS-1:0] put_val;
    logic [mbp_pkg::COUNT_W-1:0]   put_n;
    logic [mbp_pkg::COUNT_W-1:0]   total;
    logic [mbp_pkg::COUNT_W-1:0]   shamt;
    logic [2*mbp_pkg::WORD_BITS-1:0] acc;
    logic                          emit;

    assign pop = !q_status.empty && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        // align pads with a 0 then ones up to the next byte
        pad_len = 4'd8 - {1'b0, pos_reg[2:0]};
        if (head.kind == mbp_pkg::OP_ALIGN)
        begin
            put_val = (32'd1 << (pad_len - 4'd1)) - 32'd1;
            put_n   = {2'b00, pad_len};
        end
        else
        begin
            put_val = head.value;
            put_n   = head.nbits;
        end
        total = {1'b0, pos_reg} + put_n;
        shamt = 6'(7'd64 - {2'b00, pos_reg} - {1'b0, put_n});
        acc   = {pend_reg, 32'd0} | ({32'd0, put_val} << shamt);

        pend_next      = pend_reg;
        pos_next       = pos_reg;
        emit           = 1'b0;
        word_next      = acc[63:32];
        used_next      = 6'd32;
        out_valid_next = out_valid_reg && !out_ch.ready;

        if (pop)
        begin
            case (head.kind)
                mbp_pkg::OP_WRITE, mbp_pkg::OP_ALIGN:
                begin
                    if (!(head.kind == mbp_pkg::OP_ALIGN && pos_reg[2:0] == 3'd0))
                    begin
                        if (total[5])
                        begin
                            emit      = 1'b1;
                            pend_next = acc[31:0];
                            pos_next  = total[4:0];
                        end
                        else
                        begin
                            pend_next = acc[63:32];
                            pos_next  = total[4:0];
                        end
                    end
                end
                mbp_pkg::OP_FLUSH:
                begin
                    emit      = (pos_reg != 5'd0);
                    word_next = pend_reg & ~(mbp_pkg::ALL_ONES >> pos_reg);
                    used_next = {1'b0, pos_reg};
                    pend_next = '0;
                    pos_next  = '0;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg <= word_next;
            used_reg <= used_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.packed_word = word_reg;
    assign out_ch.used_bits   = used_reg;

    `ASSERT_ALWAYS(a_used_nonzero, clk, rst_n,
                   !out_valid_reg || (used_reg != 6'd0 && used_reg <= 6'd32))
    `ASSERT_NEXT(a_align_on_byte, clk, rst_n,
                 pop && head.kind == mbp_pkg::OP_ALIGN, pos_reg[2:0] == 3'd0)
    `ASSERT_NEXT(a_flush_clears, clk, rst_n,
                 pop && head.kind == mbp_pkg::OP_FLUSH,
                 pos_reg == 5'd0 && pend_reg == 32'd0)
endmodule
`default_nettype wire

>>> verif/msb_first_bit_packer_tb.sv
// testbench of the msb-first bit packer: random and directed items checked against a predictor
`default_nettype none
module msb_first_bit_packer_tb;
    localparam logic [1:0] ACT_UNKNOWN      = 2'd3;
    localparam int         LATENCY_CYCLES   = 20;
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam int         LIMIT_CYCLES     = 400000;
    localparam int         RANDOM_ITEMS     = 700;

    typedef struct {
        logic [1:0]                    action;
        logic [mbp_pkg::WORD_BITS-1:0] value;
        logic [mbp_pkg::COUNT_W-1:0]   nbits;
        int unsigned                   gap;
        bit                            drain;
        bit                            hold;
    } field_req_t;

    typedef struct {
        logic [mbp_pkg::WORD_BITS-1:0] word;
        logic [mbp_pkg::COUNT_W-1:0]   used;
    } packed_word_t;

    logic clk;
    logic rst_n;

    mbp_in_if  in_ch();
    mbp_out_if out_ch();

    msb_first_bit_packer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    field_req_t   field_reqs[$];
    packed_word_t expected_words[$];

    // predicted packer state
    logic [mbp_pkg::WORD_BITS-1:0] pend_word;
    logic [mbp_pkg::POS_W-1:0]     pend_pos;

    field_req_t  cur_req;
    bit          loaded;
    int unsigned gap_left;
    logic        hold_req;
    logic        hold_on;
    logic        hold_done;
    int unsigned hold_cnt;
    int unsigned rx_wait;
    int unsigned rx_count;
    int unsigned err_count;

    function automatic int unsigned draw_wait();
        return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 17) : 0;
    endfunction

    // append n bits after the pending ones, emitting a word when it fills
    function automatic void put_field(input logic [mbp_pkg::WORD_BITS-1:0] value,
                                      input int unsigned n);
        logic [mbp_pkg::WORD_BITS-1:0] masked;
        logic [63:0]                   acc;
        int unsigned                   total;
        masked = (n >= mbp_pkg::WORD_BITS) ? value : (value & ~(mbp_pkg::ALL_ONES << n));
        acc = {pend_word, 32'd0} | ({32'd0, masked} << (64 - int'(pend_pos) - n));
        total = pend_pos + n;
        if (total >= mbp_pkg::WORD_BITS)
        begin
            expected_words.push_back('{word: acc[63:32], used: 6'(mbp_pkg::WORD_BITS)});
            pend_word = acc[31:0];
            pend_pos  = mbp_pkg::POS_W'(total - mbp_pkg::WORD_BITS);
        end
        else
        begin
            pend_word = acc[63:32];
            pend_pos  = mbp_pkg::POS_W'(total);
        end
    endfunction

    function automatic void predict_item(input field_req_t req);
        int unsigned r;
        case (req.action)
            mbp_pkg::ACT_WRITE:
            begin
                if (req.nbits != 0)
                    put_field(req.value, (req.nbits > mbp_pkg::WORD_BITS) ?
                                         mbp_pkg::WORD_BITS : req.nbits);
            end
            mbp_pkg::ACT_ALIGN:
            begin
                r = 8 - (pend_pos & 5'd7);
                if (r == 1)
                    put_field('0, 1);
                else if (r != 8)
                    put_field((32'd1 << (r - 1)) - 32'd1, r);
            end
            mbp_pkg::ACT_FLUSH:
            begin
                if (pend_pos != 0)
                    expected_words.push_back(
                        '{word: pend_word &
                                (mbp_pkg::ALL_ONES << (mbp_pkg::WORD_BITS - pend_pos)),
                          used: 6'(pend_pos)});
                pend_word = '0;
                pend_pos  = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic void check_word(input logic [mbp_pkg::WORD_BITS-1:0] word,
                                       input logic [mbp_pkg::COUNT_W-1:0] used);
        packed_word_t exp_w;
        if (expected_words.size() == 0)
        begin
            $error("unexpected word %h used_bits %0d", word, used);
            err_count++;
        end
        else
        begin
            exp_w = expected_words.pop_front();
            if (word !== exp_w.word)
            begin
                $error("packed_word expected %h actual %h", exp_w.word, word);
                err_count++;
            end
            if (used !== exp_w.used)
            begin
                $error("used_bits expected %0d actual %0d", exp_w.used, used);
                err_count++;
            end
        end
    endfunction

    task automatic add_req(input logic [1:0] action,
                           input logic [mbp_pkg::WORD_BITS-1:0] value,
                           input logic [mbp_pkg::COUNT_W-1:0] nbits, input int unsigned gap,
                           input bit drain = 0, input bit hold = 0);
        field_reqs.push_back('{action: action, value: value, nbits: nbits, gap: gap,
                               drain: drain, hold: hold});
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("Mismatches found");
        $finish;
    end

    // driver: offers queued items, each after its own gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.action <= '0;
            in_ch.field_value <= '0;
            in_ch.field_bits <= '0;
            hold_req <= 1'b0;
            loaded = 0;
            gap_left = 0;
            pend_word = '0;
            pend_pos = '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_item(cur_req);
                if (cur_req.hold)
                    hold_req <= 1'b1;
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (!loaded && field_reqs.size() > 0)
                begin
                    cur_req = field_reqs.pop_front();
                    gap_left = cur_req.gap;
                    loaded = 1;
                end
                if (loaded && gap_left == 0 && (!cur_req.drain || expected_words.size() == 0))
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.action <= cur_req.action;
                    in_ch.field_value <= cur_req.value;
                    in_ch.field_bits <= cur_req.nbits;
                    loaded = 0;
                end
                else
                begin
                    if (loaded && gap_left > 0)
                        gap_left--;
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started once the marked item is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_req && !hold_done && !hold_on)
        begin
            hold_on <= 1'b1;
            hold_cnt <= LONG_HOLD_CYCLES;
        end
        else if (hold_on)
        begin
            if (hold_cnt == 1)
            begin
                hold_on <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_cnt <= hold_cnt - 1;
        end
    end

    // monitor: takes words and compares them in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_wait = 0;
            rx_count = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                check_word(out_ch.packed_word, out_ch.used_bits);
                rx_count++;
                // every so often a run of words taken back to back
                rx_wait = ((rx_count % 128) < 40) ? 0 : draw_wait();
            end
            else if (rx_wait > 0)
                rx_wait--;
            out_ch.ready <= (rx_wait == 0) && !hold_on;
        end
    end

    initial
    begin
        int unsigned counted;
        int unsigned sel;
        int unsigned gap;
        int unsigned seg;
        logic [1:0]  act;
        logic [31:0] val;
        logic [5:0]  nb;
        err_count = 0;

        // directed: full word, crossing, counts out of range, align cases, flush cases
        add_req(mbp_pkg::ACT_WRITE, mbp_pkg::ALL_ONES, 6'd32, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'h0000_0001, 6'd1, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'h0000_0000, 6'd32, 0);
        add_req(mbp_pkg::ACT_FLUSH, $urandom, 6'($urandom), 0);
        add_req(mbp_pkg::ACT_FLUSH, $urandom, 6'($urandom), 2);
        add_req(mbp_pkg::ACT_ALIGN, $urandom, 6'($urandom), 0);
        add_req(mbp_pkg::ACT_WRITE, mbp_pkg::ALL_ONES, 6'd0, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'hdead_beef, 6'd63, 1);
        add_req(mbp_pkg::ACT_WRITE, 32'h1234_5678, 6'd33, 0);
        add_req(ACT_UNKNOWN, mbp_pkg::ALL_ONES, 6'd63, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'h0000_007f, 6'd7, 0);
        add_req(mbp_pkg::ACT_ALIGN, '0, '0, 3);
        add_req(mbp_pkg::ACT_WRITE, 32'hffff_fff5, 6'd4, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'h0000_0005, 6'd3, 0);
        add_req(mbp_pkg::ACT_ALIGN, mbp_pkg::ALL_ONES, 6'd32, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'h2aaa_aaaa, 6'd30, 0);
        add_req(mbp_pkg::ACT_ALIGN, '0, '0, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'h7fff_ffff, 6'd31, 0);
        add_req(mbp_pkg::ACT_FLUSH, '0, '0, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'h0000_0001, 6'd1, 5);
        add_req(mbp_pkg::ACT_FLUSH, mbp_pkg::ALL_ONES, '1, 0);
        add_req(mbp_pkg::ACT_WRITE, mbp_pkg::TOP_BIT, 6'd32, 0);
        add_req(mbp_pkg::ACT_WRITE, 32'h0001_ffff, 6'd17, 0);
        add_req(mbp_pkg::ACT_ALIGN, '0, '0, 0);
        add_req(mbp_pkg::ACT_FLUSH, '0, '0, 0);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            seg = counted / 100;
            sel = $urandom_range(0, 99);
            val = $urandom;
            nb = 6'($urandom);
            if (sel < 72)
            begin
                act = mbp_pkg::ACT_WRITE;
                case ($urandom_range(0, 19))
                    0: nb = 6'd0;
                    1: nb = 6'($urandom_range(33, 63));
                    default: nb = 6'($urandom_range(1, 32));
                endcase
                case ($urandom_range(0, 19))
                    0, 1: val = mbp_pkg::ALL_ONES;
                    2: val = '0;
                    default: ;
                endcase
            end
            else if (sel < 86)
                act = mbp_pkg::ACT_ALIGN;
            else if (sel < 96)
                act = mbp_pkg::ACT_FLUSH;
            else
                act = ACT_UNKNOWN;
            gap = (seg % 3 == 1) ? 0 : draw_wait();
            add_req(act, val, nb, gap, counted == 400, counted == 100);
            if (!(act == ACT_UNKNOWN || (act == mbp_pkg::ACT_WRITE && nb == 0)))
                counted++;
        end

        @(posedge rst_n);
        while (field_reqs.size() > 0 || loaded || in_ch.valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d expected words never arrived", expected_words.size());
            err_count++;
        end
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/mbp_pkg.sv
rtl/mbp_in_if.sv
rtl/mbp_out_if.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/msb_first_bit_packer.sv
verif/msb_first_bit_packer_tb.sv
